// ===== rtl/core/qrs_pkg.sv =====
package qrs_pkg;

    // Coefficient and root formats.
    localparam int COEF_W     = 16;
    localparam int ROOT_W     = 32;
    localparam int ROOT_FRAC  = ROOT_W / 2;

    // The square root carries SQRT_EXTRA more fraction bits than the coefficients.
    localparam int SQRT_EXTRA = (63 - 2 * COEF_W - 1) / 2;
    localparam int DIV_SHIFT  = ROOT_FRAC - SQRT_EXTRA;

    // Internal widths.
    localparam int DISC_W     = 2 * COEF_W + 3;
    localparam int RAD_W      = 64;
    localparam int SQRT_W     = RAD_W / 2;
    localparam int NB_W       = COEF_W + SQRT_EXTRA + 1;
    localparam int NUM_W      = SQRT_W + 2;
    localparam int DIVN_W     = NUM_W - 1 + DIV_SHIFT;
    localparam int DEN_W      = COEF_W + 1;

    // Queue between the front and back parts.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        KIND_TWO_REAL  = 2'd0,
        KIND_COMPLEX   = 2'd1,
        KIND_REPEATED  = 2'd2,
        KIND_NOT_QUAD  = 2'd3
    } kind_t;

    // One classified equation waiting for its divisions.
    typedef struct packed {
        kind_t                    kind;
        logic signed [NUM_W-1:0]  num_a;
        logic signed [NUM_W-1:0]  num_b;
        logic signed [DEN_W-1:0]  den;
    } work_t;

endpackage

// ===== rtl/core/qrs_front.sv =====
module qrs_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
    output logic                              out_valid,
    input  logic                              out_stall,
    output qrs_pkg::work_t                    out_item
);
    import qrs_pkg::*;

    logic adv;

    // Product stage.
    logic                        v0_reg;
    logic signed [COEF_W-1:0]    a0_reg;
    logic signed [COEF_W-1:0]    b0_reg;
    logic signed [2*COEF_W-1:0]  bb_reg;
    logic signed [2*COEF_W-1:0]  ac_reg;

    // Discriminant and classification.
    logic signed [DISC_W-1:0]    disc;
    logic        [DISC_W-1:0]    disc_mag;
    kind_t                       kind_next;
    logic signed [NB_W-1:0]      nb_next;
    logic signed [DEN_W-1:0]     den_next;

    // Square root pipeline, one result bit per stage.
    logic                        v_reg    [0:SQRT_W];
    logic        [RAD_W-1:0]     x_reg    [0:SQRT_W];
    logic        [RAD_W-1:0]     r_reg    [0:SQRT_W];
    kind_t                       kind_reg [0:SQRT_W];
    logic signed [NB_W-1:0]      nb_reg   [0:SQRT_W];
    logic signed [DEN_W-1:0]     den_reg  [0:SQRT_W];

    // Numerator stage.
    logic                        fv_reg;
    work_t                       item_reg;
    work_t                       item_next;
    logic signed [NUM_W-1:0]     nb_ext;
    logic signed [NUM_W-1:0]     s_ext;

    assign adv      = !fv_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a0_reg <= coef_a;
            b0_reg <= coef_b;
            bb_reg <= coef_b * coef_b;
            ac_reg <= coef_a * coef_c;
        end
    end

    always_comb
    begin
        disc     = DISC_W'(bb_reg) - (DISC_W'(ac_reg) <<< 2);
        disc_mag = disc[DISC_W-1] ? DISC_W'(0) - disc : disc;
        nb_next  = -(NB_W'(b0_reg)) <<< SQRT_EXTRA;
        den_next = DEN_W'(a0_reg) <<< 1;
        if (a0_reg == '0)
        begin
            kind_next = KIND_NOT_QUAD;
        end
        else if (disc[DISC_W-1])
        begin
            kind_next = KIND_COMPLEX;
        end
        else if (disc == '0)
        begin
            kind_next = KIND_REPEATED;
        end
        else
        begin
            kind_next = KIND_TWO_REAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]    <= RAD_W'(disc_mag) << (2 * SQRT_EXTRA);
            r_reg[0]    <= '0;
            kind_reg[0] <= kind_next;
            nb_reg[0]   <= nb_next;
            den_reg[0]  <= den_next;
        end
    end

    for (genvar k = 0; k < SQRT_W; k++)
    begin : g_sqrt
        localparam logic [RAD_W-1:0] BITV = RAD_W'(1) << (RAD_W - 2 - 2 * k);
        logic [RAD_W-1:0] trial;
        logic [RAD_W-1:0] x_next;
        logic [RAD_W-1:0] r_next;

        assign trial = r_reg[k] + BITV;

        always_comb
        begin
            if (x_reg[k] >= trial)
            begin
                x_next = x_reg[k] - trial;
                r_next = (r_reg[k] >> 1) + BITV;
            end
            else
            begin
                x_next = x_reg[k];
                r_next = r_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[k+1]    <= x_next;
                r_reg[k+1]    <= r_next;
                kind_reg[k+1] <= kind_reg[k];
                nb_reg[k+1]   <= nb_reg[k];
                den_reg[k+1]  <= den_reg[k];
            end
        end
    end

    // Two real roots use -b +/- s; otherwise the first divider takes -b and
    // the second takes s for the imaginary part.
    always_comb
    begin
        nb_ext         = NUM_W'(nb_reg[SQRT_W]);
        s_ext          = {2'b00, r_reg[SQRT_W][SQRT_W-1:0]};
        item_next.kind = kind_reg[SQRT_W];
        item_next.den  = den_reg[SQRT_W];
        if (kind_reg[SQRT_W] == KIND_TWO_REAL)
        begin
            item_next.num_a = nb_ext + s_ext;
            item_next.num_b = nb_ext - s_ext;
        end
        else
        begin
            item_next.num_a = nb_ext;
            item_next.num_b = s_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (adv)
        begin
            fv_reg <= v_reg[SQRT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = fv_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/core/qrs_queue.sv =====
module qrs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  qrs_pkg::work_t in_item,
    output logic           out_valid,
    input  logic           out_stall,
    output qrs_pkg::work_t out_item
);
    import qrs_pkg::*;

    work_t              mem_reg [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;
    logic               full;
    logic               push;
    logic               pop;

    assign full      = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign in_stall  = full;
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && !full;
    assign pop       = out_valid && !out_stall;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(push) && !$past(pop) |-> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");
`endif

endmodule

// ===== rtl/core/qrs_back.sv =====
module qrs_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  qrs_pkg::work_t                    in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        root_kind,
    output logic signed [qrs_pkg::ROOT_W-1:0] first_root,
    output logic signed [qrs_pkg::ROOT_W-1:0] second_root,
    output logic [qrs_pkg::ROOT_W-2:0]        imag_part,
    output logic                              overflow
);
    import qrs_pkg::*;

    localparam logic [DIVN_W-1:0] HALF    = DIVN_W'(1) << (ROOT_W - 1);
    localparam logic [ROOT_W-1:0] MIN_VAL = {1'b1, {(ROOT_W-1){1'b0}}};
    localparam logic [ROOT_W-1:0] MAX_VAL = {1'b0, {(ROOT_W-1){1'b1}}};

    logic adv;

    // Divider pipeline, one quotient bit per stage for each of two dividers.
    logic               v_reg    [0:DIVN_W];
    kind_t              kind_reg [0:DIVN_W];
    logic               nega_reg [0:DIVN_W];
    logic               negb_reg [0:DIVN_W];
    logic [DEN_W-1:0]   dv_reg   [0:DIVN_W];
    logic [DEN_W-1:0]   rema_reg [0:DIVN_W];
    logic [DEN_W-1:0]   remb_reg [0:DIVN_W];
    logic [DIVN_W-1:0]  dnda_reg [0:DIVN_W];
    logic [DIVN_W-1:0]  dndb_reg [0:DIVN_W];

    logic [NUM_W-1:0]   mag_a;
    logic [NUM_W-1:0]   mag_b;
    logic [DEN_W-1:0]   mag_den;
    logic               neg_a;
    logic               neg_b;

    // Output register.
    logic               ov_reg;
    kind_t              kind_o_reg;
    logic [ROOT_W-1:0]  r1_reg;
    logic [ROOT_W-1:0]  r2_reg;
    logic [ROOT_W-2:0]  im_reg;
    logic               ovf_reg;
    logic [ROOT_W-1:0]  r1_next;
    logic [ROOT_W-1:0]  r2_next;
    logic [ROOT_W-2:0]  im_next;
    logic               ovf_next;
    logic [ROOT_W:0]    root_a;
    logic [ROOT_W:0]    root_b;
    logic               im_sat;
    logic [ROOT_W-2:0]  im_val;

    function automatic logic [ROOT_W:0] sat_root(input logic [DIVN_W-1:0] q,
                                                 input logic neg);
        logic              s;
        logic [ROOT_W-1:0] v;
        if (neg)
        begin
            s = (q > HALF);
            v = s ? MIN_VAL : ROOT_W'(DIVN_W'(~q) + DIVN_W'(1));
        end
        else
        begin
            s = (q >= HALF);
            v = s ? MAX_VAL : q[ROOT_W-1:0];
        end
        return {s, v};
    endfunction

    assign adv      = !ov_reg || !out_stall;
    assign in_stall = !adv;

    always_comb
    begin
        mag_a   = in_item.num_a[NUM_W-1] ? NUM_W'(0) - in_item.num_a : in_item.num_a;
        mag_b   = in_item.num_b[NUM_W-1] ? NUM_W'(0) - in_item.num_b : in_item.num_b;
        mag_den = in_item.den[DEN_W-1] ? DEN_W'(0) - in_item.den : in_item.den;
        neg_a   = in_item.num_a[NUM_W-1] ^ in_item.den[DEN_W-1];
        neg_b   = (in_item.kind == KIND_TWO_REAL)
                  && (in_item.num_b[NUM_W-1] ^ in_item.den[DEN_W-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_reg[0] <= in_item.kind;
            nega_reg[0] <= neg_a;
            negb_reg[0] <= neg_b;
            dv_reg[0]   <= mag_den;
            rema_reg[0] <= '0;
            remb_reg[0] <= '0;
            dnda_reg[0] <= DIVN_W'(mag_a) << DIV_SHIFT;
            dndb_reg[0] <= DIVN_W'(mag_b) << DIV_SHIFT;
        end
    end

    for (genvar i = 0; i < DIVN_W; i++)
    begin : g_div
        logic [DEN_W:0]   trial_a;
        logic [DEN_W:0]   trial_b;
        logic             ge_a;
        logic             ge_b;
        logic [DEN_W-1:0] rema_next;
        logic [DEN_W-1:0] remb_next;

        always_comb
        begin
            trial_a   = {rema_reg[i], dnda_reg[i][DIVN_W-1]};
            trial_b   = {remb_reg[i], dndb_reg[i][DIVN_W-1]};
            ge_a      = (trial_a >= {1'b0, dv_reg[i]});
            ge_b      = (trial_b >= {1'b0, dv_reg[i]});
            rema_next = ge_a ? DEN_W'(trial_a - {1'b0, dv_reg[i]}) : trial_a[DEN_W-1:0];
            remb_next = ge_b ? DEN_W'(trial_b - {1'b0, dv_reg[i]}) : trial_b[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                kind_reg[i+1] <= kind_reg[i];
                nega_reg[i+1] <= nega_reg[i];
                negb_reg[i+1] <= negb_reg[i];
                dv_reg[i+1]   <= dv_reg[i];
                rema_reg[i+1] <= rema_next;
                remb_reg[i+1] <= remb_next;
                dnda_reg[i+1] <= {dnda_reg[i][DIVN_W-2:0], ge_a};
                dndb_reg[i+1] <= {dndb_reg[i][DIVN_W-2:0], ge_b};
            end
        end
    end

    // Saturate the quotients and assemble the result for the kind of equation.
    always_comb
    begin
        root_a = sat_root(dnda_reg[DIVN_W], nega_reg[DIVN_W]);
        root_b = sat_root(dndb_reg[DIVN_W], negb_reg[DIVN_W]);
        im_sat = (dndb_reg[DIVN_W] >= HALF);
        im_val = im_sat ? {(ROOT_W-1){1'b1}} : dndb_reg[DIVN_W][ROOT_W-2:0];
        case (kind_reg[DIVN_W])
            KIND_TWO_REAL:
            begin
                r1_next  = root_a[ROOT_W-1:0];
                r2_next  = root_b[ROOT_W-1:0];
                im_next  = '0;
                ovf_next = root_a[ROOT_W] | root_b[ROOT_W];
            end
            KIND_COMPLEX:
            begin
                r1_next  = root_a[ROOT_W-1:0];
                r2_next  = root_a[ROOT_W-1:0];
                im_next  = im_val;
                ovf_next = root_a[ROOT_W] | im_sat;
            end
            KIND_REPEATED:
            begin
                r1_next  = root_a[ROOT_W-1:0];
                r2_next  = root_a[ROOT_W-1:0];
                im_next  = '0;
                ovf_next = root_a[ROOT_W];
            end
            default:
            begin
                r1_next  = '0;
                r2_next  = '0;
                im_next  = '0;
                ovf_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            ov_reg <= v_reg[DIVN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_o_reg <= kind_reg[DIVN_W];
            r1_reg     <= r1_next;
            r2_reg     <= r2_next;
            im_reg     <= im_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign out_valid   = ov_reg;
    assign root_kind   = kind_o_reg;
    assign first_root  = r1_reg;
    assign second_root = r2_reg;
    assign imag_part   = im_reg;
    assign overflow    = ovf_reg;

`ifndef SYNTHESIS
    a_not_quad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && (kind_o_reg == KIND_NOT_QUAD)
        |-> (r1_reg == '0) && (r2_reg == '0) && !ovf_reg)
        else $error("zero a gave nonzero result");

    a_imag_only_complex: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && (kind_o_reg != KIND_COMPLEX) |-> (im_reg == '0))
        else $error("imaginary part on a real result");

    a_single_root: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && ((kind_o_reg == KIND_COMPLEX) || (kind_o_reg == KIND_REPEATED))
        |-> (r1_reg == r2_reg))
        else $error("repeated or complex roots differ");
`endif

endmodule

// ===== rtl/core/quadratic_root_solver_unit.sv =====
// Quadratic root solver. Each item carries the coefficients a, b and c of
// a*x^2 + b*x + c as signed Q8.8 values, and each produces exactly one result:
// root_kind (0 two distinct real roots, 1 complex pair, 2 one repeated root,
// 3 a is zero), first_root and second_root in signed Q16.16 (for a complex pair
// both hold the real part -b/2a), imag_part as the unsigned Q15.16 magnitude of
// the imaginary part, and overflow when any value saturated to the Q16.16 or
// Q15.16 range. Square root and division truncate toward zero; a zero a gives
// all-zero roots. The block takes one item every cycle while in_stall is low
// and has no configuration. An item runs through a front part (products,
// discriminant, a 32-stage square root that settles one result bit per stage,
// numerator forming), a four-entry queue, and a back part of two 34-stage
// restoring dividers followed by saturation and the output register. The
// queue lets the front keep taking items while the output is stalled, until
// its four entries are full.
module quadratic_root_solver_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        root_kind,
    output logic signed [qrs_pkg::ROOT_W-1:0] first_root,
    output logic signed [qrs_pkg::ROOT_W-1:0] second_root,
    output logic [qrs_pkg::ROOT_W-2:0]        imag_part,
    output logic                              overflow
);
    import qrs_pkg::*;

    // Front to queue.
    logic  fq_valid;
    logic  fq_stall;
    work_t fq_item;

    // Queue to back.
    logic  qb_valid;
    logic  qb_stall;
    work_t qb_item;

    qrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .coef_a    (coef_a),
        .coef_b    (coef_b),
        .coef_c    (coef_c),
        .out_valid (fq_valid),
        .out_stall (fq_stall),
        .out_item  (fq_item)
    );

    qrs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_stall  (fq_stall),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_stall (qb_stall),
        .out_item  (qb_item)
    );

    qrs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (qb_valid),
        .in_stall    (qb_stall),
        .in_item     (qb_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .root_kind   (root_kind),
        .first_root  (first_root),
        .second_root (second_root),
        .imag_part   (imag_part),
        .overflow    (overflow)
    );

endmodule
